// ===== hdl/sct_pkg.sv =====
// Shared constants, result codes and width helpers for the segment crossing test.
`default_nettype none

package sct_pkg;

    // Fixed widths of the ports and the number of pipeline stages.
    localparam int LON_W     = 31;
    localparam int LAT_W     = 30;
    localparam int CFG_W     = 30;
    localparam int CFG_IDX_W = 2;
    localparam int CODE_W    = 3;
    localparam int STAGES    = 8;

    // Result codes.
    localparam logic [CODE_W-1:0] CODE_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_POS      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_NEG      = 3'd2;
    localparam logic [CODE_W-1:0] CODE_UNSURE   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_ZERO_SEG = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_PARALLEL  = 30'd3518;
    localparam logic [CFG_W-1:0] RST_EDGE      = 30'd214748;
    localparam logic [CFG_W-1:0] RST_INTERCEPT = 30'd839;

    // Width of an unwrapped longitude; two unwrap steps of 360 degrees may be added.
    function automatic int sct_x_width(input int c);
        int b;
        begin
            b = (c + 10 > LON_W) ? c + 10 : LON_W;
            return b + 2;
        end
    endfunction

    // Width of a difference of two latitudes.
    function automatic int sct_dy_width();
        return LAT_W + 1;
    endfunction

    // Width of one exact cross product.
    function automatic int sct_p_width(input int c);
        return sct_x_width(c) + 1 + sct_dy_width();
    endfunction

    // Width of the denominator and the numerators.
    function automatic int sct_d_width(input int c);
        return sct_p_width(c) + 1;
    endfunction

    // Width of the intercept sum.
    function automatic int sct_t_width(input int c);
        int a;
        int b;
        begin
            a = sct_p_width(c) + sct_x_width(c);
            b = sct_dy_width() + 2 * c;
            return ((a > b) ? a : b) + 2;
        end
    endfunction

    // Width of the scaled compares in the fraction judge.
    function automatic int sct_j_width(input int c, input int r);
        return sct_d_width(c) + r + 33;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sct_unwrap.sv =====
// First pipeline stage: longitude unwrap of both segments.
`default_nettype none

module sct_unwrap #(
    parameter int COORD_FRAC_BITS = 22
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [sct_pkg::LON_W-1:0]      first_start_lon,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      first_start_lat,
    input  wire logic signed [sct_pkg::LON_W-1:0]      first_end_lon,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      first_end_lat,
    input  wire logic signed [sct_pkg::LON_W-1:0]      second_start_lon,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      second_start_lat,
    input  wire logic signed [sct_pkg::LON_W-1:0]      second_end_lon,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      second_end_lat,
    output logic signed [sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] x1,
    output logic signed [sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] x2,
    output logic signed [sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] x3,
    output logic signed [sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] x4,
    output logic signed [sct_pkg::LAT_W-1:0]           y1,
    output logic signed [sct_pkg::LAT_W-1:0]           y2,
    output logic signed [sct_pkg::LAT_W-1:0]           y3,
    output logic signed [sct_pkg::LAT_W-1:0]           y4
);
    import sct_pkg::*;

    localparam int XW = sct_x_width(COORD_FRAC_BITS);
    localparam logic signed [XW-1:0] FULL = XW'(64'd360 << COORD_FRAC_BITS);
    localparam logic signed [XW-1:0] HALF = XW'(64'd180 << COORD_FRAC_BITS);

    logic signed [XW-1:0] u1, u2, u3, u4, d1, d2;
    logic signed [XW-1:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic signed [LAT_W-1:0] y1_reg, y2_reg, y3_reg, y4_reg;

    // Unwrap chain: the first segment, then the second segment.
    always_comb
    begin
        u1 = XW'(first_start_lon);
        u2 = XW'(first_end_lon);
        u3 = XW'(second_start_lon);
        u4 = XW'(second_end_lon);
        d1 = u1 - u2;
        if (d1 > HALF || d1 < -HALF)
        begin
            if (u1[XW-1])
                u1 = u1 + FULL;
            else if (u2[XW-1])
                u2 = u2 + FULL;
            if (u3[XW-1])
            begin
                u3 = u3 + FULL;
                u4 = u4 + FULL;
            end
        end
        d2 = u3 - u4;
        if (d2 > HALF || d2 < -HALF)
        begin
            if (u3[XW-1])
                u3 = u3 + FULL;
            else if (u3 >= FULL)
                u3 = u3 - FULL;
            else if (u4[XW-1])
                u4 = u4 + FULL;
            else if (u4 >= FULL)
                u4 = u4 - FULL;
            if (u1[XW-1])
            begin
                u1 = u1 + FULL;
                u2 = u2 + FULL;
            end
        end
    end

    // Stage register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= u1;
            x2_reg <= u2;
            x3_reg <= u3;
            x4_reg <= u4;
            y1_reg <= first_start_lat;
            y2_reg <= first_end_lat;
            y3_reg <= second_start_lat;
            y4_reg <= second_end_lat;
        end
    end

    assign x1 = x1_reg;
    assign x2 = x2_reg;
    assign x3 = x3_reg;
    assign x4 = x4_reg;
    assign y1 = y1_reg;
    assign y2 = y2_reg;
    assign y3 = y3_reg;
    assign y4 = y4_reg;

endmodule

`default_nettype wire

// ===== hdl/sct_products.sv =====
// Stages two to four: differences, cross products, denominator and intercept partials.
`default_nettype none

module sct_products #(
    parameter int COORD_FRAC_BITS = 22
) (
    input  wire logic                                  clk,
    input  wire logic [2:0]                            en,
    input  wire logic signed [sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] x1,
    input  wire logic signed [sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] x2,
    input  wire logic signed [sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] x3,
    input  wire logic signed [sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] x4,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      y1,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      y2,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      y3,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      y4,
    output logic signed [sct_pkg::sct_d_width(COORD_FRAC_BITS)-1:0] den,
    output logic signed [sct_pkg::sct_d_width(COORD_FRAC_BITS)-1:0] na,
    output logic signed [sct_pkg::sct_d_width(COORD_FRAC_BITS)-1:0] nb,
    output logic signed [sct_pkg::sct_p_width(COORD_FRAC_BITS)/2
                         + sct_pkg::sct_x_width(COORD_FRAC_BITS):0] q1_lo,
    output logic signed [sct_pkg::sct_p_width(COORD_FRAC_BITS)
                         - sct_pkg::sct_p_width(COORD_FRAC_BITS)/2
                         + sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] q1_hi,
    output logic signed [sct_pkg::sct_p_width(COORD_FRAC_BITS)/2
                         + sct_pkg::sct_x_width(COORD_FRAC_BITS):0] q2_lo,
    output logic signed [sct_pkg::sct_p_width(COORD_FRAC_BITS)
                         - sct_pkg::sct_p_width(COORD_FRAC_BITS)/2
                         + sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] q2_hi,
    output logic signed [sct_pkg::sct_dy_width()-1:0]  cy,
    output logic                                       zero_a
);
    import sct_pkg::*;

    localparam int XW  = sct_x_width(COORD_FRAC_BITS);
    localparam int DXW = XW + 1;
    localparam int DYW = sct_dy_width();
    localparam int PW  = sct_p_width(COORD_FRAC_BITS);
    localparam int DW  = sct_d_width(COORD_FRAC_BITS);
    localparam int LO  = PW / 2;
    localparam int QLW = LO + 1 + XW;
    localparam int QHW = PW - LO + XW;

    // Stage two: differences.
    logic signed [DXW-1:0] ax_reg, bx_reg, cx_reg;
    logic signed [DYW-1:0] ay_reg, by_reg, cy2_reg;
    logic signed [XW-1:0]  x1_s2_reg, x3_s2_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ax_reg    <= DXW'(x2) - DXW'(x1);
            bx_reg    <= DXW'(x3) - DXW'(x4);
            cx_reg    <= DXW'(x1) - DXW'(x3);
            ay_reg    <= DYW'(y2) - DYW'(y1);
            by_reg    <= DYW'(y3) - DYW'(y4);
            cy2_reg   <= DYW'(y1) - DYW'(y3);
            x1_s2_reg <= x1;
            x3_s2_reg <= x3;
        end
    end

    // Stage three: the six cross products.
    logic signed [PW-1:0] p_aybx_reg, p_axby_reg, p_bycx_reg;
    logic signed [PW-1:0] p_bxcy_reg, p_axcy_reg, p_aycx_reg;
    logic signed [XW-1:0] x1_s3_reg, x3_s3_reg;
    logic signed [DYW-1:0] cy3_reg;
    logic zero_a3_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_aybx_reg  <= PW'(ay_reg) * PW'(bx_reg);
            p_axby_reg  <= PW'(ax_reg) * PW'(by_reg);
            p_bycx_reg  <= PW'(by_reg) * PW'(cx_reg);
            p_bxcy_reg  <= PW'(bx_reg) * PW'(cy2_reg);
            p_axcy_reg  <= PW'(ax_reg) * PW'(cy2_reg);
            p_aycx_reg  <= PW'(ay_reg) * PW'(cx_reg);
            x1_s3_reg   <= x1_s2_reg;
            x3_s3_reg   <= x3_s2_reg;
            cy3_reg     <= cy2_reg;
            zero_a3_reg <= (ax_reg == '0) && (ay_reg == '0);
        end
    end

    // Stage four: denominator, numerators and the split intercept products.
    logic signed [DW-1:0]  den_reg, na_reg, nb_reg;
    logic signed [QLW-1:0] q1_lo_reg, q2_lo_reg;
    logic signed [QHW-1:0] q1_hi_reg, q2_hi_reg;
    logic signed [DYW-1:0] cy4_reg;
    logic zero_a4_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            den_reg     <= DW'(p_aybx_reg) - DW'(p_axby_reg);
            na_reg      <= DW'(p_bycx_reg) - DW'(p_bxcy_reg);
            nb_reg      <= DW'(p_axcy_reg) - DW'(p_aycx_reg);
            q1_lo_reg   <= QLW'($signed({1'b0, p_aybx_reg[LO-1:0]})) * QLW'(x1_s3_reg);
            q1_hi_reg   <= QHW'($signed(p_aybx_reg[PW-1:LO])) * QHW'(x1_s3_reg);
            q2_lo_reg   <= QLW'($signed({1'b0, p_axby_reg[LO-1:0]})) * QLW'(x3_s3_reg);
            q2_hi_reg   <= QHW'($signed(p_axby_reg[PW-1:LO])) * QHW'(x3_s3_reg);
            cy4_reg     <= cy3_reg;
            zero_a4_reg <= zero_a3_reg;
        end
    end

    assign den    = den_reg;
    assign na     = na_reg;
    assign nb     = nb_reg;
    assign q1_lo  = q1_lo_reg;
    assign q1_hi  = q1_hi_reg;
    assign q2_lo  = q2_lo_reg;
    assign q2_hi  = q2_hi_reg;
    assign cy     = cy4_reg;
    assign zero_a = zero_a4_reg;

endmodule

`default_nettype wire

// ===== hdl/sct_classify.sv =====
// Stages five to eight: parallel test, intercept test, fraction judge and result code.
`default_nettype none

module sct_classify #(
    parameter int COORD_FRAC_BITS = 22,
    parameter int RATIO_FRAC_BITS = 30
) (
    input  wire logic                                  clk,
    input  wire logic [3:0]                            en,
    input  wire logic [sct_pkg::CFG_W-1:0]             parallel_threshold,
    input  wire logic [sct_pkg::CFG_W-1:0]             edge_margin,
    input  wire logic [sct_pkg::CFG_W-1:0]             intercept_margin,
    input  wire logic signed [sct_pkg::sct_d_width(COORD_FRAC_BITS)-1:0] den,
    input  wire logic signed [sct_pkg::sct_d_width(COORD_FRAC_BITS)-1:0] na,
    input  wire logic signed [sct_pkg::sct_d_width(COORD_FRAC_BITS)-1:0] nb,
    input  wire logic signed [sct_pkg::sct_p_width(COORD_FRAC_BITS)/2
                              + sct_pkg::sct_x_width(COORD_FRAC_BITS):0] q1_lo,
    input  wire logic signed [sct_pkg::sct_p_width(COORD_FRAC_BITS)
                              - sct_pkg::sct_p_width(COORD_FRAC_BITS)/2
                              + sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] q1_hi,
    input  wire logic signed [sct_pkg::sct_p_width(COORD_FRAC_BITS)/2
                              + sct_pkg::sct_x_width(COORD_FRAC_BITS):0] q2_lo,
    input  wire logic signed [sct_pkg::sct_p_width(COORD_FRAC_BITS)
                              - sct_pkg::sct_p_width(COORD_FRAC_BITS)/2
                              + sct_pkg::sct_x_width(COORD_FRAC_BITS)-1:0] q2_hi,
    input  wire logic signed [sct_pkg::sct_dy_width()-1:0] cy,
    input  wire logic                                  zero_a,
    output logic [sct_pkg::CODE_W-1:0]                 crossing_code
);
    import sct_pkg::*;

    localparam int PW  = sct_p_width(COORD_FRAC_BITS);
    localparam int DW  = sct_d_width(COORD_FRAC_BITS);
    localparam int LO  = PW / 2;
    localparam int TW  = sct_t_width(COORD_FRAC_BITS);
    localparam int JW  = sct_j_width(COORD_FRAC_BITS, RATIO_FRAC_BITS);
    localparam int L2  = DW / 2;
    localparam int MLW = CFG_W + L2;
    localparam int MHW = CFG_W + DW - L2;

    // Stage five: sign fold, parallel test and intercept sum.
    logic [DW-1:0]         den_abs5;
    logic [DW-1:0]         den_abs5_reg;
    logic signed [DW-1:0]  na5_reg, nb5_reg;
    logic signed [TW-1:0]  t5_reg;
    logic                  neg5_reg, par5_reg, zero_a5_reg;

    assign den_abs5 = den[DW-1] ? DW'(-den) : DW'(den);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            den_abs5_reg <= den_abs5;
            na5_reg      <= den[DW-1] ? -na : na;
            nb5_reg      <= den[DW-1] ? -nb : nb;
            neg5_reg     <= den[DW-1];
            par5_reg     <= (den == '0) || (den_abs5 < DW'(parallel_threshold));
            t5_reg       <= (TW'(cy) <<< (2 * COORD_FRAC_BITS))
                            + (TW'(q2_hi) <<< LO) + TW'(q2_lo)
                            - (TW'(q1_hi) <<< LO) - TW'(q1_lo);
            zero_a5_reg  <= zero_a;
        end
    end

    // Stage six: intercept magnitude compare and the margin products.
    logic [TW-1:0]        t_abs6;
    logic [MLW-1:0]       mlo6_reg;
    logic [MHW-1:0]       mhi6_reg;
    logic [DW-1:0]        den_abs6_reg;
    logic signed [DW-1:0] na6_reg, nb6_reg;
    logic                 neg6_reg, par6_reg, over6_reg, zero_a6_reg;

    assign t_abs6 = t5_reg[TW-1] ? TW'(-t5_reg) : TW'(t5_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mlo6_reg     <= MLW'(edge_margin) * MLW'(den_abs5_reg[L2-1:0]);
            mhi6_reg     <= MHW'(edge_margin) * MHW'(den_abs5_reg[DW-1:L2]);
            over6_reg    <= t_abs6 > (TW'(intercept_margin) << (2 * COORD_FRAC_BITS));
            den_abs6_reg <= den_abs5_reg;
            na6_reg      <= na5_reg;
            nb6_reg      <= nb5_reg;
            neg6_reg     <= neg5_reg;
            par6_reg     <= par5_reg;
            zero_a6_reg  <= zero_a5_reg;
        end
    end

    // Stage seven: recombine the margin product.
    logic signed [JW-1:0] md7_reg;
    logic [DW-1:0]        den_abs7_reg;
    logic signed [DW-1:0] na7_reg, nb7_reg;
    logic                 neg7_reg, par7_reg, over7_reg, zero_a7_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            md7_reg      <= $signed((JW'(mhi6_reg) << L2) + JW'(mlo6_reg));
            den_abs7_reg <= den_abs6_reg;
            na7_reg      <= na6_reg;
            nb7_reg      <= nb6_reg;
            neg7_reg     <= neg6_reg;
            par7_reg     <= par6_reg;
            over7_reg    <= over6_reg;
            zero_a7_reg  <= zero_a6_reg;
        end
    end

    // Stage eight: judge both fractions against the scaled denominator.
    logic signed [JW-1:0] s_a, s_b, d_r;
    logic out_a, out_b, edge_a, edge_b;
    logic [CODE_W-1:0] code8;
    logic [CODE_W-1:0] code_reg;

    always_comb
    begin
        s_a    = JW'(na7_reg) <<< RATIO_FRAC_BITS;
        s_b    = JW'(nb7_reg) <<< RATIO_FRAC_BITS;
        d_r    = $signed(JW'(den_abs7_reg) << RATIO_FRAC_BITS);
        out_a  = (s_a < -md7_reg) || ((d_r + md7_reg) < s_a);
        out_b  = (s_b < -md7_reg) || ((d_r + md7_reg) < s_b);
        edge_a = (s_a < md7_reg) || ((d_r - md7_reg) < s_a);
        edge_b = (s_b < md7_reg) || ((d_r - md7_reg) < s_b);
        if (par7_reg)
        begin
            if (over7_reg)
                code8 = CODE_NONE;
            else if (zero_a7_reg)
                code8 = CODE_ZERO_SEG;
            else
                code8 = CODE_UNSURE;
        end
        else if (out_a || out_b)
            code8 = CODE_NONE;
        else if (edge_a || edge_b)
            code8 = CODE_UNSURE;
        else if (neg7_reg)
            code8 = CODE_NEG;
        else
            code8 = CODE_POS;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            code_reg <= code8;
    end

    assign crossing_code = code_reg;

endmodule

`default_nettype wire

// ===== hdl/segment_crossing_test_parametric.sv =====
// Top level of the segment crossing test: configuration registers and pipeline control.
//
// Usage: each input beat on the in_valid/in_ready channel carries two segments as four
// lon/lat points. Each beat yields exactly one output beat on out_valid/out_ready
// carrying crossing_code, in input order.
// The datapath is an eight-stage pipeline: unwrap, differences, cross products,
// denominator and intercept partials, sign fold and parallel test, margin products,
// margin recombine, and the final judge. One beat is taken per cycle when the receiver
// keeps up; the rate is set by the single pass through the stages, each stage holding one
// item. Each stage holds its item only while the stage after it is full and stalled, so
// bubbles are squeezed out and in_ready stays high while any stage is empty. When the
// receiver stalls, the output stage holds its beat and up to eight beats, the output
// stage's included, are held before in_ready drops. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle: a rule for the user, which the block
// does not enforce. Reset clears every stage valid bit and loads the default register
// values.
`default_nettype none

module segment_crossing_test_parametric #(
    parameter int COORD_FRAC_BITS = 22,
    parameter int RATIO_FRAC_BITS = 30
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [sct_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [sct_pkg::CFG_W-1:0]             cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [sct_pkg::LON_W-1:0]      first_start_lon,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      first_start_lat,
    input  wire logic signed [sct_pkg::LON_W-1:0]      first_end_lon,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      first_end_lat,
    input  wire logic signed [sct_pkg::LON_W-1:0]      second_start_lon,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      second_start_lat,
    input  wire logic signed [sct_pkg::LON_W-1:0]      second_end_lon,
    input  wire logic signed [sct_pkg::LAT_W-1:0]      second_end_lat,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [sct_pkg::CODE_W-1:0]                 crossing_code
);
    import sct_pkg::*;

    localparam int XW  = sct_x_width(COORD_FRAC_BITS);
    localparam int DW  = sct_d_width(COORD_FRAC_BITS);
    localparam int DYW = sct_dy_width();
    localparam int PW  = sct_p_width(COORD_FRAC_BITS);
    localparam int QLW = PW / 2 + XW + 1;
    localparam int QHW = PW - PW / 2 + XW;

    // Configuration registers.
    logic [CFG_W-1:0] thr_reg, edge_reg, icpt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= RST_PARALLEL;
            edge_reg <= RST_EDGE;
            icpt_reg <= RST_INTERCEPT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PARALLEL:  thr_reg  <= cfg_data;
                CFG_EDGE:      edge_reg <= cfg_data;
                CFG_INTERCEPT: icpt_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Stage valid bits and the per-stage load enables.
    logic [STAGES-1:0] v_reg, v_next, en;

    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < STAGES; k++)
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];

    // Datapath.
    logic signed [XW-1:0]    x1, x2, x3, x4;
    logic signed [LAT_W-1:0] y1, y2, y3, y4;
    logic signed [DW-1:0]    den, na, nb;
    logic signed [QLW-1:0]   q1_lo, q2_lo;
    logic signed [QHW-1:0]   q1_hi, q2_hi;
    logic signed [DYW-1:0]   cy;
    logic                    zero_a;

    sct_unwrap #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_unwrap (
        .clk              (clk),
        .en               (en[0]),
        .first_start_lon  (first_start_lon),
        .first_start_lat  (first_start_lat),
        .first_end_lon    (first_end_lon),
        .first_end_lat    (first_end_lat),
        .second_start_lon (second_start_lon),
        .second_start_lat (second_start_lat),
        .second_end_lon   (second_end_lon),
        .second_end_lat   (second_end_lat),
        .x1               (x1),
        .x2               (x2),
        .x3               (x3),
        .x4               (x4),
        .y1               (y1),
        .y2               (y2),
        .y3               (y3),
        .y4               (y4)
    );

    sct_products #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_products (
        .clk    (clk),
        .en     (en[3:1]),
        .x1     (x1),
        .x2     (x2),
        .x3     (x3),
        .x4     (x4),
        .y1     (y1),
        .y2     (y2),
        .y3     (y3),
        .y4     (y4),
        .den    (den),
        .na     (na),
        .nb     (nb),
        .q1_lo  (q1_lo),
        .q1_hi  (q1_hi),
        .q2_lo  (q2_lo),
        .q2_hi  (q2_hi),
        .cy     (cy),
        .zero_a (zero_a)
    );

    sct_classify #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_classify (
        .clk                (clk),
        .en                 (en[7:4]),
        .parallel_threshold (thr_reg),
        .edge_margin        (edge_reg),
        .intercept_margin   (icpt_reg),
        .den                (den),
        .na                 (na),
        .nb                 (nb),
        .q1_lo              (q1_lo),
        .q1_hi              (q1_hi),
        .q2_lo              (q2_lo),
        .q2_hi              (q2_hi),
        .cy                 (cy),
        .zero_a             (zero_a),
        .crossing_code      (crossing_code)
    );

    // An empty stage anywhere means the pipeline can take a beat.
    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(&v_reg) |-> in_ready)
        else $error("in_ready low while a pipeline stage is empty");

    // An accepted beat always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted beat lost at the first stage");

    // A taken result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !v_reg[STAGES-2]) |=> !out_valid)
        else $error("result repeated after it was taken");

    // Only defined codes leave the block.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (crossing_code == CODE_NONE || crossing_code == CODE_POS
                       || crossing_code == CODE_NEG || crossing_code == CODE_UNSURE
                       || crossing_code == CODE_ZERO_SEG))
        else $error("undefined crossing code");

endmodule

`default_nettype wire
